// ===== hw/rtl/rc_pkg.sv =====
// rc_pkg: shared widths, state encodings, register indexes and helpers
// for the radix converter. Depends on nothing; used by every rc_* module.
package rc_pkg;

    localparam int IN_W           = 30;
    localparam int BASE_W         = 4;
    localparam int DIGIT_W        = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 4;

    localparam int MAX_IN_DIGITS  = 9;
    localparam int MAX_OUT_DIGITS = 30;

    // Binary to BCD conversion of the input, two bits per cycle.
    localparam int BCD_DIGITS     = 10;
    localparam int BCD_W          = BCD_DIGITS * DIGIT_W;
    localparam int BCD_BITS       = 2;
    localparam int BCD_CYCLES     = IN_W / BCD_BITS;
    localparam int BCD_CNT_W      = $clog2(BCD_CYCLES);
    localparam int IN_IDX_W       = $clog2(BCD_DIGITS);

    // Long division by the output base, eight quotient bits per cycle.
    localparam int DIV_BITS       = 8;
    localparam int DIV_CHUNKS     = (IN_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W          = DIV_CHUNKS * DIV_BITS;
    localparam int CHUNK_W        = $clog2(DIV_CHUNKS);
    localparam int STORE_IDX_W    = $clog2(MAX_OUT_DIGITS);
    localparam int COUNT_W        = $clog2(MAX_OUT_DIGITS + 1);

    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = 2'd1;

    localparam logic [BASE_W-1:0] BASE_MIN      = 4'd2;
    localparam logic [BASE_W-1:0] BASE_MAX      = 4'd10;
    localparam logic [BASE_W-1:0] IN_BASE_RST   = 4'd10;
    localparam logic [BASE_W-1:0] OUT_BASE_RST  = 4'd2;

    typedef logic [IN_W-1:0] value_t;

    typedef enum logic [3:0] {
        FS_IDLE   = 4'b0001,
        FS_BCD    = 4'b0010,
        FS_HORNER = 4'b0100,
        FS_PUSH   = 4'b1000
    } front_state_t;

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_DIV  = 3'b010,
        BS_EMIT = 3'b100
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN)
        begin
            r = BASE_MIN;
        end
        else if (b > BASE_MAX)
        begin
            r = BASE_MAX;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/radix_converter.sv =====
// radix_converter: top level of the radix converter; holds the base
// registers and joins front, queue and back. Depends on rc_pkg and rc_*.
//
// Usage: coded_value is taken on the input channel when in_valid is high
// and in_stall low. Its lowest nine decimal digits are read as digits in
// in_base and the value is sent back as digits in out_base on the output
// channel, most significant first, last_digit marking the final digit.
// A zero value gives a single digit 0. Bases outside 2..10 saturate.
// Configuration: cfg_write with cfg_index 0 (in_base) or 1 (out_base)
// writes cfg_data at that edge; write only while the block is idle.
// The front accepts a value, converts it from binary to BCD, folds the
// nine digits in in_base and queues the result. The back divides it by
// out_base, the divider loop yielding 8 quotient bits per cycle, stores
// each remainder as a digit and then sends the stored digits. The slower
// side sets the throughput: the front for runs of up to five digits,
// the back beyond that.
// Reset sets in_base to 10 and out_base to 2 and empties the queue.
// A stalled output holds its digit; the back then waits while the front
// keeps taking items until the two-entry queue fills.
module radix_converter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rc_pkg::IN_W-1:0]         coded_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rc_pkg::DIGIT_W-1:0]      digit,
    output logic                            last_digit,
    input  logic                            cfg_write,
    input  logic [rc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [rc_pkg::BASE_W-1:0]  in_base_reg, in_base_next;
    logic [rc_pkg::BASE_W-1:0]  out_base_reg, out_base_next;

    rc_pkg::q_status_t          q_status;
    logic                       q_push;
    logic                       q_pop;
    rc_pkg::value_t             q_push_data;
    rc_pkg::value_t             q_pop_data;

    always_comb
    begin
        in_base_next  = in_base_reg;
        out_base_next = out_base_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                rc_pkg::REG_IN_BASE:  in_base_next  = cfg_data;
                rc_pkg::REG_OUT_BASE: out_base_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_base_reg  <= rc_pkg::IN_BASE_RST;
            out_base_reg <= rc_pkg::OUT_BASE_RST;
        end
        else
        begin
            in_base_reg  <= in_base_next;
            out_base_reg <= out_base_next;
        end
    end

    rc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coded_value (coded_value),
        .in_base     (in_base_reg),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    rc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    rc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .out_base   (out_base_reg),
        .q_status   (q_status),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .digit      (digit),
        .last_digit (last_digit)
    );

endmodule

// ===== hw/rtl/rc_front.sv =====
// rc_front: accepts a coded value, splits it into decimal digits and
// folds them into a binary value in the input base. Depends on rc_pkg.
module rc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  rc_pkg::value_t              coded_value,
    input  logic [rc_pkg::BASE_W-1:0]   in_base,
    input  rc_pkg::q_status_t           q_status,
    output logic                        q_push,
    output rc_pkg::value_t              q_data
);

    localparam int WORK_W = rc_pkg::BCD_W + rc_pkg::IN_W;
    localparam int PROD_W = rc_pkg::IN_W + rc_pkg::BASE_W;

    rc_pkg::front_state_t               state_reg, state_next;
    logic [rc_pkg::BCD_CNT_W-1:0]       step_reg, step_next;
    logic [rc_pkg::IN_IDX_W-1:0]        idx_reg, idx_next;
    logic [WORK_W-1:0]                  work_reg, work_next;
    rc_pkg::value_t                     acc_reg, acc_next;

    logic [WORK_W-1:0]                  dd_work;
    logic [rc_pkg::BASE_W-1:0]          b1;
    logic [PROD_W-1:0]                  prod;
    logic [rc_pkg::DIGIT_W-1:0]         cur_digit;
    rc_pkg::value_t                     horner_sum;

    assign b1 = rc_pkg::clamp_base(in_base);

    // Shift-and-add-3 over all BCD lanes, several bits per cycle.
    always_comb
    begin
        dd_work = work_reg;
        for (int s = 0; s < rc_pkg::BCD_BITS; s++)
        begin
            for (int l = 0; l < rc_pkg::BCD_DIGITS; l++)
            begin
                if (dd_work[rc_pkg::IN_W + l*rc_pkg::DIGIT_W +: rc_pkg::DIGIT_W] >= 4'd5)
                begin
                    dd_work[rc_pkg::IN_W + l*rc_pkg::DIGIT_W +: rc_pkg::DIGIT_W] =
                        dd_work[rc_pkg::IN_W + l*rc_pkg::DIGIT_W +: rc_pkg::DIGIT_W] + 4'd3;
                end
            end
            dd_work = {dd_work[WORK_W-2:0], 1'b0};
        end
    end

    assign cur_digit  = work_reg[rc_pkg::IN_W + idx_reg*rc_pkg::DIGIT_W +: rc_pkg::DIGIT_W];
    assign prod       = {{rc_pkg::BASE_W{1'b0}}, acc_reg} * {{rc_pkg::IN_W{1'b0}}, b1};
    assign horner_sum = prod[rc_pkg::IN_W-1:0]
                        + {{(rc_pkg::IN_W-rc_pkg::DIGIT_W){1'b0}}, cur_digit};

    assign in_stall = (state_reg != rc_pkg::FS_IDLE);
    assign q_push   = (state_reg == rc_pkg::FS_PUSH) && !q_status.full;
    assign q_data   = acc_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        work_next  = work_reg;
        acc_next   = acc_reg;
        case (state_reg)
            rc_pkg::FS_IDLE:
            begin
                if (in_valid)
                begin
                    work_next  = {{rc_pkg::BCD_W{1'b0}}, coded_value};
                    step_next  = '0;
                    state_next = rc_pkg::FS_BCD;
                end
            end
            rc_pkg::FS_BCD:
            begin
                work_next = dd_work;
                step_next = step_reg + 1'b1;
                if (step_reg == rc_pkg::BCD_CNT_W'(rc_pkg::BCD_CYCLES - 1))
                begin
                    acc_next   = '0;
                    idx_next   = rc_pkg::IN_IDX_W'(rc_pkg::MAX_IN_DIGITS - 1);
                    state_next = rc_pkg::FS_HORNER;
                end
            end
            rc_pkg::FS_HORNER:
            begin
                // Most significant used digit first; digits above the limit are ignored.
                acc_next = horner_sum;
                idx_next = idx_reg - 1'b1;
                if (idx_reg == '0)
                begin
                    state_next = rc_pkg::FS_PUSH;
                end
            end
            rc_pkg::FS_PUSH:
            begin
                if (!q_status.full)
                begin
                    state_next = rc_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = rc_pkg::FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rc_pkg::FS_IDLE;
            step_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        acc_reg  <= acc_next;
    end

endmodule

// ===== hw/rtl/rc_queue.sv =====
// rc_queue: short FIFO of converted values between front and back.
// Depends on rc_pkg.
module rc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rc_pkg::value_t      push_data,
    input  logic                pop,
    output rc_pkg::value_t      pop_data,
    output rc_pkg::q_status_t   status
);

    rc_pkg::value_t                 mem [rc_pkg::QUEUE_DEPTH];
    logic [rc_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [rc_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [rc_pkg::QUEUE_CW-1:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign status.full  = (count_reg == rc_pkg::QUEUE_CW'(rc_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == rc_pkg::QUEUE_AW'(rc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == rc_pkg::QUEUE_AW'(rc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/rc_back.sv =====
// rc_back: divides each queued value by the output base, stores the
// remainders and sends them out most significant first. Depends on rc_pkg.
module rc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rc_pkg::BASE_W-1:0]   out_base,
    input  rc_pkg::q_status_t           q_status,
    input  rc_pkg::value_t              q_data,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rc_pkg::DIGIT_W-1:0]  digit,
    output logic                        last_digit
);

    rc_pkg::back_state_t                state_reg, state_next;
    logic [rc_pkg::CHUNK_W-1:0]         chunk_reg, chunk_next;
    logic [rc_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [rc_pkg::STORE_IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [rc_pkg::DIV_W-1:0]           quo_reg, quo_next;
    logic [rc_pkg::BASE_W-1:0]          rem_reg, rem_next;
    logic                               out_valid_reg, out_valid_next;
    logic [rc_pkg::DIGIT_W-1:0]         digit_reg;
    logic                               last_digit_reg;

    logic [rc_pkg::DIGIT_W-1:0]         digit_store [rc_pkg::MAX_OUT_DIGITS];
    logic                               st_we;
    logic                               out_load;

    logic [rc_pkg::BASE_W-1:0]          b2;
    logic [rc_pkg::DIV_W-1:0]           q_work;
    logic [rc_pkg::BASE_W-1:0]          r_work;
    logic [rc_pkg::BASE_W:0]            t_work;

    assign b2 = rc_pkg::clamp_base(out_base);

    // One restoring-division step per quotient bit; the remainder stays below the base.
    always_comb
    begin
        q_work = quo_reg;
        r_work = rem_reg;
        t_work = '0;
        for (int j = 0; j < rc_pkg::DIV_BITS; j++)
        begin
            t_work = {r_work, q_work[rc_pkg::DIV_W-1]};
            q_work = {q_work[rc_pkg::DIV_W-2:0], 1'b0};
            if (t_work >= {1'b0, b2})
            begin
                t_work    = t_work - {1'b0, b2};
                q_work[0] = 1'b1;
            end
            r_work = t_work[rc_pkg::BASE_W-1:0];
        end
    end

    assign out_load = (state_reg == rc_pkg::BS_EMIT) && (!out_valid_reg || !out_stall);
    assign st_we    = (state_reg == rc_pkg::BS_DIV)
                      && (chunk_reg == rc_pkg::CHUNK_W'(rc_pkg::DIV_CHUNKS - 1));
    assign q_pop    = (state_reg == rc_pkg::BS_IDLE) && !q_status.empty;

    always_comb
    begin
        state_next     = state_reg;
        chunk_next     = chunk_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            rc_pkg::BS_IDLE:
            begin
                if (!q_status.empty)
                begin
                    quo_next   = {{(rc_pkg::DIV_W-rc_pkg::IN_W){1'b0}}, q_data};
                    rem_next   = '0;
                    chunk_next = '0;
                    count_next = '0;
                    state_next = rc_pkg::BS_DIV;
                end
            end
            rc_pkg::BS_DIV:
            begin
                quo_next   = q_work;
                rem_next   = r_work;
                chunk_next = chunk_reg + 1'b1;
                if (st_we)
                begin
                    // Digit done: a zero value still yields its single digit 0.
                    rem_next   = '0;
                    chunk_next = '0;
                    count_next = count_reg + 1'b1;
                    if ((q_work == '0)
                        || (count_reg == rc_pkg::COUNT_W'(rc_pkg::MAX_OUT_DIGITS - 1)))
                    begin
                        rd_idx_next = count_reg[rc_pkg::STORE_IDX_W-1:0];
                        state_next  = rc_pkg::BS_EMIT;
                    end
                end
            end
            rc_pkg::BS_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg - 1'b1;
                    if (rd_idx_reg == '0)
                    begin
                        state_next = rc_pkg::BS_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rc_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc_pkg::BS_IDLE;
            chunk_reg     <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chunk_reg     <= chunk_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        if (st_we)
        begin
            digit_store[count_reg[rc_pkg::STORE_IDX_W-1:0]] <= r_work;
        end
        if (out_load)
        begin
            digit_reg      <= digit_store[rd_idx_reg];
            last_digit_reg <= (rd_idx_reg == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign digit      = digit_reg;
    assign last_digit = last_digit_reg;

`ifndef ASSERT_OFF
    a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc_pkg::BS_DIV) |-> (rem_reg < b2))
        else $error("division remainder not below the output base");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc_pkg::BS_EMIT)
            |-> (rd_idx_reg < count_reg))
        else $error("emit index outside the stored digits");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rc_pkg::COUNT_W'(rc_pkg::MAX_OUT_DIGITS))
        else $error("digit count above the store depth");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (rd_idx_reg == '0)) |=> (state_reg == rc_pkg::BS_IDLE))
        else $error("back end did not finish after the last digit");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for radix_converter: directed table plus random values,
// scored digit by digit against typed-in digits or a behavioral model of the base conversion.
// Depends on rc_pkg and the radix_converter RTL.
module testbench;

    localparam logic [rc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [rc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int DIRECTED_ROWS  = 20;
    localparam int RANDOM_BATCHES = 10;
    localparam int BATCH_ITEMS    = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [rc_pkg::DIGIT_W-1:0] value;
        logic                       is_last;
    } digit_slot_t;

    // One directed row: bases to use, the input, and optionally the typed-in digits
    // (one hex nibble per output digit, least significant digit in the lowest nibble).
    typedef struct packed {
        logic [rc_pkg::BASE_W-1:0]  in_b;
        logic [rc_pkg::BASE_W-1:0]  out_b;
        logic [rc_pkg::IN_W-1:0]    coded;
        logic                       typed;
        logic [4:0]                 n_digits;
        logic [119:0]               digits;
    } dir_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [rc_pkg::IN_W-1:0]       coded_value = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [rc_pkg::DIGIT_W-1:0]    digit;
    logic                          last_digit;
    logic                          cfg_write = 1'b0;
    logic [rc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    digit_slot_t pending_digits[$];
    logic [rc_pkg::BASE_W-1:0] in_radix_reg = rc_pkg::IN_BASE_RST;
    logic [rc_pkg::BASE_W-1:0] out_radix_reg = rc_pkg::OUT_BASE_RST;

    int  sender_idle_pct = 0;
    int  receiver_idle_pct = 0;
    bit  hold_request = 1'b0;
    bit  hold_seen = 1'b0;
    int  hold_left = 0;
    int  fail_count = 0;
    int  values_sent = 0;
    int  digits_checked = 0;
    int  settings_used = 1;
    int  longest_run = 0;
    int  quiet_cycles = 0;

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        '{4'd10, 4'd2,  30'd0,          1'b1, 5'd1,  120'h0},
        '{4'd10, 4'd2,  30'd1,          1'b1, 5'd1,  120'h1},
        '{4'd10, 4'd2,  30'd5,          1'b1, 5'd3,  120'h101},
        '{4'd10, 4'd2,  30'd999999999,  1'b0, 5'd0,  120'h0},
        '{4'd10, 4'd2,  30'h3FFFFFFF,   1'b0, 5'd0,  120'h0},
        '{4'd10, 4'd2,  30'd1000000000, 1'b1, 5'd1,  120'h0},
        '{4'd10, 4'd10, 30'd123,        1'b1, 5'd3,  120'h123},
        '{4'd10, 4'd10, 30'd999999999,  1'b1, 5'd9,  120'h999999999},
        '{4'd2,  4'd10, 30'd101,        1'b1, 5'd1,  120'h5},
        '{4'd2,  4'd10, 30'd111111111,  1'b1, 5'd3,  120'h511},
        '{4'd2,  4'd10, 30'd9,          1'b1, 5'd1,  120'h9},
        '{4'd2,  4'd10, 30'd222,        1'b1, 5'd2,  120'h14},
        '{4'd0,  4'd15, 30'd1101,       1'b1, 5'd2,  120'h13},
        '{4'd15, 4'd0,  30'd6,          1'b1, 5'd3,  120'h110},
        '{4'd1,  4'd11, 30'd11,         1'b1, 5'd1,  120'h3},
        '{4'd9,  4'd9,  30'd88,         1'b1, 5'd2,  120'h88},
        '{4'd9,  4'd9,  30'd999999999,  1'b0, 5'd0,  120'h0},
        '{4'd3,  4'd7,  30'd12021,      1'b0, 5'd0,  120'h0},
        '{4'd10, 4'd3,  30'd59048,      1'b1, 5'd10, 120'h2222222222},
        '{4'd10, 4'd9,  30'd0,          1'b1, 5'd1,  120'h0}
    };

    radix_converter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .coded_value (coded_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digit       (digit),
        .last_digit  (last_digit),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int saturate_radix(input logic [rc_pkg::BASE_W-1:0] r);
        int b;
        b = r;
        if (b < rc_pkg::BASE_MIN)
        begin
            b = rc_pkg::BASE_MIN;
        end
        else if (b > rc_pkg::BASE_MAX)
        begin
            b = rc_pkg::BASE_MAX;
        end
        return b;
    endfunction

    // Reads the lowest nine decimal digits as input-base digits and queues the
    // output-base digits, most significant first.
    function automatic void predict_digits(input logic [rc_pkg::IN_W-1:0] cv);
        longint unsigned rest;
        longint unsigned weight;
        longint unsigned acc;
        int in_b;
        int out_b;
        int cnt;
        logic [rc_pkg::DIGIT_W-1:0] rev [rc_pkg::MAX_OUT_DIGITS];
        digit_slot_t slot;
        in_b = saturate_radix(in_radix_reg);
        out_b = saturate_radix(out_radix_reg);
        rest = cv;
        weight = 1;
        acc = 0;
        cnt = 0;
        for (int i = 0; i < rc_pkg::MAX_IN_DIGITS; i++)
        begin
            acc += (rest % 10) * weight;
            rest /= 10;
            weight *= in_b;
        end
        if (acc == 0)
        begin
            rev[0] = '0;
            cnt = 1;
        end
        else
        begin
            while (acc > 0 && cnt < rc_pkg::MAX_OUT_DIGITS)
            begin
                rev[cnt] = rc_pkg::DIGIT_W'(acc % out_b);
                acc /= out_b;
                cnt++;
            end
        end
        for (int k = 0; k < cnt; k++)
        begin
            slot.value = rev[cnt - 1 - k];
            slot.is_last = (k == cnt - 1);
            pending_digits.push_back(slot);
        end
        if (cnt > longest_run)
        begin
            longest_run = cnt;
        end
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // Picks a value: plain 30-bit noise, a proper input-base number, a small one,
    // or one with ten decimal digits whose top digit must be dropped.
    function automatic logic [rc_pkg::IN_W-1:0] pick_coded_value();
        int sel;
        int len;
        int in_b;
        longint unsigned v;
        sel = $urandom_range(99);
        in_b = saturate_radix(in_radix_reg);
        v = 0;
        if (sel < 35)
        begin
            v = $urandom() & 32'h3FFFFFFF;
        end
        else if (sel < 70)
        begin
            len = $urandom_range(9, 1);
            for (int i = 0; i < len; i++)
            begin
                v = v * 10 + $urandom_range(in_b - 1);
            end
        end
        else if (sel < 85)
        begin
            v = $urandom_range(99);
        end
        else
        begin
            v = $urandom_range(32'h3FFFFFFF, 1000000000);
        end
        return rc_pkg::IN_W'(v);
    endfunction

    task automatic send_value(input logic [rc_pkg::IN_W-1:0] cv, input logic typed,
                              input logic [4:0] n_digits, input logic [119:0] digits);
        digit_slot_t slot;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        coded_value <= cv;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (typed)
        begin
            for (int k = 0; k < n_digits; k++)
            begin
                slot.value = digits[(n_digits - 1 - k) * rc_pkg::DIGIT_W +: rc_pkg::DIGIT_W];
                slot.is_last = (k == n_digits - 1);
                pending_digits.push_back(slot);
            end
        end
        else
        begin
            predict_digits(cv);
        end
        values_sent++;
        @(negedge clk);
    endtask

    // Base registers change only once every queued digit has come out.
    task automatic set_bases(input logic [rc_pkg::BASE_W-1:0] in_b,
                             input logic [rc_pkg::BASE_W-1:0] out_b);
        in_valid <= 1'b0;
        while (pending_digits.size() != 0)
        begin
            @(negedge clk);
        end
        cfg_write <= 1'b1;
        cfg_index <= rc_pkg::REG_IN_BASE;
        cfg_data <= in_b;
        @(negedge clk);
        cfg_index <= REG_SPARE_A;
        cfg_data <= rc_pkg::CFG_DATA_W'($urandom());
        @(negedge clk);
        cfg_index <= rc_pkg::REG_OUT_BASE;
        cfg_data <= out_b;
        @(negedge clk);
        cfg_index <= REG_SPARE_B;
        cfg_data <= rc_pkg::CFG_DATA_W'($urandom());
        @(negedge clk);
        cfg_write <= 1'b0;
        in_radix_reg = in_b;
        out_radix_reg = out_b;
        settings_used++;
        @(negedge clk);
    endtask

    function automatic logic [rc_pkg::BASE_W-1:0] pick_base();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            return rc_pkg::BASE_MIN;
        end
        else if (sel < 30)
        begin
            return rc_pkg::BASE_MAX;
        end
        else if (sel < 42)
        begin
            return ($urandom_range(1) == 0) ? rc_pkg::BASE_W'($urandom_range(1))
                                            : rc_pkg::BASE_W'($urandom_range(15, 11));
        end
        return rc_pkg::BASE_W'($urandom_range(10, 2));
    endfunction

    // Receiver: random stalls, plus a long counted hold-off on request.
    always @(negedge clk)
    begin
        if (hold_request != hold_seen)
        begin
            hold_seen = hold_request;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        digit_slot_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            digits_checked++;
            if (pending_digits.size() == 0)
            begin
                note_failure($sformatf("digit %0d last %0b arrived with nothing outstanding",
                                       digit, last_digit));
            end
            else
            begin
                want = pending_digits.pop_front();
                if (digit !== want.value || last_digit !== want.is_last)
                begin
                    note_failure($sformatf("digit %0d last %0b, wanted digit %0d last %0b",
                                           digit, last_digit, want.value, want.is_last));
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("** radix_converter: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        dir_row_t row;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        sender_idle_pct = 6;
        receiver_idle_pct = 57;
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = directed_rows[r];
            if (row.in_b != in_radix_reg || row.out_b != out_radix_reg)
            begin
                set_bases(row.in_b, row.out_b);
            end
            send_value(row.coded, row.typed, row.n_digits, row.digits);
        end

        for (int b = 0; b < RANDOM_BATCHES; b++)
        begin
            if (b == 0)
            begin
                set_bases(rc_pkg::BASE_MAX, rc_pkg::BASE_MIN);
            end
            else if (b == RANDOM_BATCHES - 1)
            begin
                set_bases(rc_pkg::BASE_MIN, rc_pkg::BASE_MAX);
            end
            else
            begin
                set_bases(pick_base(), pick_base());
            end
            if (b < 4)
            begin
                sender_idle_pct = 6;
                receiver_idle_pct = 57;
            end
            else if (b < 8)
            begin
                sender_idle_pct = 57;
                receiver_idle_pct = 6;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            // Hold the output off while values keep coming so the input stalls.
            if (b == 2 || b == 8)
            begin
                hold_request = ~hold_request;
            end
            for (int i = 0; i < BATCH_ITEMS; i++)
            begin
                send_value(pick_coded_value(), 1'b0, 5'd0, 120'h0);
            end
        end

        in_valid <= 1'b0;
        while (pending_digits.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d values under %0d base settings; %0d digits came back,",
                 values_sent, settings_used, digits_checked);
        $display("longest run %0d digits, with input and output stalls and a long hold-off.",
                 longest_run);
        if (fail_count == 0)
        begin
            $display("** radix_converter: PASSED **");
        end
        else
        begin
            $display("%0d mismatches in total", fail_count);
            $display("** radix_converter: FAILED **");
        end
        $finish;
    end

endmodule
